### sv/sdx_pkg.sv
package sdx_pkg;

  localparam logic [7:0] PAD_CHAR   = 8'd48;  // '0'
  localparam logic [7:0] VOWEL_CODE = 8'd57;  // '9'
  localparam logic [7:0] SPACE_CHAR = 8'd32;  // ' '
  localparam logic [4:0] CODE_LEN_RESET = 5'd4;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       char_present;
    logic       word_end;
  } sdx_item_t;

  function automatic logic [7:0] sdx_upper(input logic [7:0] b);
    logic [7:0] u;
    u = b;
    if (b >= 8'd97 && b <= 8'd122) begin
      u = b - 8'd32;
    end
    return u;
  endfunction

  // Fixed code table; lowercase 'w' is the odd one out and codes as '0'.
  function automatic logic [7:0] sdx_rom(input logic [7:0] b);
    logic [7:0] u;
    logic [7:0] c;
    u = sdx_upper(b);
    unique case (u)
      8'd65, 8'd69, 8'd73, 8'd79, 8'd85, 8'd89:                c = VOWEL_CODE;
      8'd66, 8'd70, 8'd80, 8'd86, 8'd87, 8'd222:               c = 8'd49;
      8'd67, 8'd71, 8'd74, 8'd75, 8'd81, 8'd83, 8'd88, 8'd90,
      8'd199, 8'd215, 8'd223, 8'd231:                          c = 8'd50;
      8'd68, 8'd84, 8'd208, 8'd254:                            c = 8'd51;
      8'd76:                                                   c = 8'd52;
      8'd77, 8'd78, 8'd209, 8'd241:                            c = 8'd53;
      8'd82:                                                   c = 8'd54;
      default:                                                 c = PAD_CHAR;
    endcase
    if (b == 8'd119) begin
      c = PAD_CHAR;
    end
    return c;
  endfunction

endpackage

### sv/sdx_in_reg.sv
module sdx_in_reg
  import sdx_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  sdx_item_t in_item,
  output logic      item_valid,
  output sdx_item_t item,
  input  logic      item_take
);

  assign in_ready = !item_valid || item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

### sv/sdx_core.sv
module sdx_core
  import sdx_pkg::*;
#(
  parameter int MAX_CODE_LEN = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [4:0] code_length,
  input  logic       item_valid,
  input  sdx_item_t  item,
  output logic       item_take,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] code_char,
  output logic       code_last
);

  localparam int CW = $clog2(MAX_CODE_LEN + 1);
  localparam int LW = (CW > 5) ? CW : 5;

  logic [CW-1:0] emitted_count;
  logic          at_word_start;
  logic [7:0]    previous_code;
  logic          code_complete;
  logic          char_done;     // byte handled, item now in padding

  logic [LW-1:0] len_wide;
  logic [CW-1:0] len;
  logic [CW-1:0] cnt_inc;
  logic [7:0]    rom_c;
  logic          complete_now;
  logic          do_char;
  logic          do_pad;
  logic          emit;
  logic          finish;
  logic          out_free;
  logic          advance;

  always_comb begin
    len_wide = LW'(code_length);
    if (code_length == 5'd0) begin
      len_wide = LW'(1);
    end else if (len_wide > LW'(MAX_CODE_LEN)) begin
      len_wide = LW'(MAX_CODE_LEN);
    end
  end
  assign len = CW'(len_wide);

  assign rom_c        = sdx_rom(item.char_byte);
  assign complete_now = code_complete || (emitted_count >= len);
  assign do_char      = !char_done && item.char_present && !complete_now &&
                        (at_word_start ||
                         (rom_c != PAD_CHAR && rom_c != VOWEL_CODE &&
                          rom_c != previous_code));
  assign do_pad       = !do_char && item.word_end && (emitted_count < len);
  assign emit         = do_char || do_pad;
  assign cnt_inc      = emitted_count + CW'(1);
  assign finish       = !emit || !item.word_end || (cnt_inc >= len);
  assign out_free     = !out_valid || out_ready;
  assign advance      = item_valid && (!emit || out_free);
  assign item_take    = advance && finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      emitted_count <= '0;
      at_word_start <= 1'b1;
      previous_code <= SPACE_CHAR;
      code_complete <= 1'b0;
      char_done     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (advance && emit) begin
        out_valid <= 1'b1;
        code_last <= (cnt_inc == len);
        if (do_char) begin
          code_char <= at_word_start ? sdx_upper(item.char_byte) : rom_c;
        end else begin
          code_char <= PAD_CHAR;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        char_done <= !finish;
        if (finish && item.word_end) begin
          emitted_count <= '0;
          at_word_start <= 1'b1;
          previous_code <= SPACE_CHAR;
          code_complete <= 1'b0;
        end else begin
          if (emit) begin
            emitted_count <= cnt_inc;
          end
          if (emit && (cnt_inc >= len)) begin
            code_complete <= 1'b1;
          end else if (!char_done) begin
            code_complete <= complete_now;
          end
          if (!char_done && item.char_present && !complete_now) begin
            if (at_word_start) begin
              previous_code <= item.char_byte;
              at_word_start <= 1'b0;
            end else begin
              previous_code <= rom_c;
            end
          end
        end
      end
    end
  end

endmodule

### sv/soundex_code_generator_unit.sv
// An input transaction passes the input register (sdx_in_reg), then the output register of sdx_core.
// Throughput: one input transaction per cycle unless out_ready stalls; a transaction
//   yielding n code characters (its byte plus any end-of-word padding) holds the input
//   until all n are out, one char per cycle (out_ready high) via the single output register.
// Reset (rst, synchronous): word state cleared, code_length back to 4.
module soundex_code_generator_unit
  import sdx_pkg::*;
#(
  parameter int MAX_CODE_LEN = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [4:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_byte,
  input  logic       char_present,
  input  logic       word_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] code_char,
  output logic       code_last
);

  logic [4:0] code_length;
  sdx_item_t  in_item;
  sdx_item_t  item;
  logic       item_valid;
  logic       item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_length <= CODE_LEN_RESET;
    end else if (cfg_wr_en) begin
      code_length <= cfg_wr_data;
    end
  end

  assign in_item.char_byte    = char_byte;
  assign in_item.char_present = char_present;
  assign in_item.word_end     = word_end;

  sdx_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  sdx_core #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .code_length (code_length),
    .item_valid  (item_valid),
    .item        (item),
    .item_take   (item_take),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .code_char   (code_char),
    .code_last   (code_last)
  );

endmodule

### tb/sv/soundex_code_generator_unit_test.sv
module soundex_code_generator_unit_test;
  import sdx_pkg::*;

  localparam int MAX_LEN      = 16;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int PHASE_ITEMS  = 52;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } code_char_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic [4:0] cfg_wr_data = 5'd0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] char_byte = 8'd0;
  logic       char_present = 1'b0;
  logic       word_end = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] code_char;
  logic       code_last;

  soundex_code_generator_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .char_byte   (char_byte),
    .char_present(char_present),
    .word_end    (word_end),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .code_char   (code_char),
    .code_last   (code_last)
  );

  always #5 clk = ~clk;

  sdx_item_t  pending_items[$];
  code_char_t code_q[$];

  int idle_pct  = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int sent_cnt = 0;
  int checked_cnt = 0;
  int word_cnt = 0;
  int cycles = 0;

  // latin-1 bytes that carry a code of their own
  logic [7:0] latin_bytes [0:8] = '{8'd199, 8'd215, 8'd223, 8'd231, 8'd208,
                                    8'd254, 8'd209, 8'd241, 8'd222};

  // shadow of the block state
  logic [4:0]  len_reg = CODE_LEN_RESET;
  int unsigned emitted = 0;
  bit          at_start = 1'b1;
  logic [7:0]  prev_code = SPACE_CHAR;
  bit          full = 1'b0;

  function automatic logic [7:0] soundex_digit(input logic [7:0] b);
    logic [7:0] u;
    if (b == "w") return PAD_CHAR;
    u = (b >= "a" && b <= "z") ? b - 8'd32 : b;
    case (u)
      "A", "E", "I", "O", "U", "Y": return VOWEL_CODE;
      "B", "F", "P", "V", "W", 8'd222: return "1";
      "C", "G", "J", "K", "Q", "S", "X", "Z",
      8'd199, 8'd215, 8'd223, 8'd231: return "2";
      "D", "T", 8'd208, 8'd254: return "3";
      "L": return "4";
      "M", "N", 8'd209, 8'd241: return "5";
      "R": return "6";
      default: return PAD_CHAR;
    endcase
  endfunction

  function automatic int unsigned active_length();
    if (len_reg == 5'd0) return 1;
    if (len_reg > MAX_LEN) return MAX_LEN;
    return len_reg;
  endfunction

  function automatic void push_code(input logic [7:0] ch, input int unsigned len);
    emitted++;
    if (emitted >= len) full = 1'b1;
    code_q.push_back('{ch: ch, fin: (emitted == len)});
  endfunction

  function automatic void predict_code(input logic [7:0] b, input logic present,
                                       input logic end_flag);
    int unsigned len;
    logic [7:0] c;
    int n;
    len = active_length();
    n = 0;
    if (emitted >= len) full = 1'b1;
    if (present && !full) begin
      if (at_start) begin
        push_code((b >= "a" && b <= "z") ? b - 8'd32 : b, len);
        n++;
        // raw first byte, so a digit-valued first byte suppresses a matching code
        prev_code = b;
        at_start = 1'b0;
      end else begin
        c = soundex_digit(b);
        if (c != PAD_CHAR && c != VOWEL_CODE && c != prev_code) begin
          push_code(c, len);
          n++;
        end
        prev_code = c;
      end
    end
    if (end_flag) begin
      while (emitted < len && n < MAX_LEN) begin
        push_code(PAD_CHAR, len);
        n++;
      end
      emitted = 0;
      at_start = 1'b1;
      prev_code = SPACE_CHAR;
      full = 1'b0;
      word_cnt++;
    end
  endfunction

  function automatic void push_item(input logic [7:0] b, input logic present,
                                    input logic end_flag);
    pending_items.push_back('{char_byte: b, char_present: present, word_end: end_flag});
  endfunction

  function automatic void push_text(input string s, input bit close);
    for (int i = 0; i < s.len(); i++) begin
      push_item(s[i], 1'b1, close && (i == s.len() - 1));
    end
    if (close && s.len() == 0) push_item(8'd0, 1'b0, 1'b1);
  endfunction

  // returns the number of transactions that carry a byte or a word end
  function automatic int add_random_word();
    int nb;
    int cnt;
    bit tail_end;
    logic [7:0] b;
    nb = ($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(8);
    tail_end = ($urandom_range(1) == 1) && (nb > 0);
    cnt = 0;
    for (int i = 0; i < nb; i++) begin
      case ($urandom_range(9))
        0, 1, 2: b = 8'($urandom_range(255));
        3:       b = latin_bytes[4'($urandom_range(8))];
        default: b = 8'd65 + 8'($urandom_range(25)) + ($urandom_range(1) ? 8'd32 : 8'd0);
      endcase
      if ($urandom_range(19) == 0) push_item(8'($urandom_range(255)), 1'b0, 1'b0);
      push_item(b, 1'b1, tail_end && (i == nb - 1));
      cnt++;
    end
    if (!tail_end) begin
      push_item(8'($urandom_range(255)), 1'b0, 1'b1);
      cnt++;
    end
    return cnt;
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || code_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_length(input logic [4:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    len_reg = v;
  endtask

  // driver
  always @(posedge clk) begin : drive_items
    sdx_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_code(char_byte, char_present, word_end);
        sent_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
          it = pending_items.pop_front();
          in_valid <= 1'b1;
          char_byte <= it.char_byte;
          char_present <= it.char_present;
          word_end <= it.word_end;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : check_codes
    code_char_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (code_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected code char %0d last %0b", code_char, code_last);
        end else begin
          want = code_q.pop_front();
          checked_cnt++;
          if (code_char !== want.ch || code_last !== want.fin) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected char %0d last %0b, got char %0d last %0b",
                       want.ch, want.fin, code_char, code_last);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[soundex_code_generator_unit] ERROR");
      $finish;
    end
  end

  initial begin
    logic [4:0] phase_len [0:5];
    int phase_idle [0:5];
    int phase_stall [0:5];
    int cnt;
    phase_len   = '{5'd1, 5'd16, 5'd31, 5'd0, 5'($urandom_range(31)), 5'($urandom_range(31))};
    phase_idle  = '{0, 50, 0, 13, 0, 13};
    phase_stall = '{0, 0, 50, 13, 0, 13};

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed words at the reset length of 4
    push_text("", 1);
    push_text("Robert", 1);
    push_text("wWh", 0);
    push_item(8'h00, 1'b0, 1'b0);     // empty transaction mid-word
    push_item(8'hFF, 1'b1, 1'b1);
    push_item(8'h00, 1'b1, 1'b0);
    push_item(8'h80, 1'b1, 1'b1);
    push_text("1b", 1);               // digit first byte hides matching code
    push_item("x", 1'b1, 1'b0);
    push_item(8'd199, 1'b1, 1'b0);
    push_item(8'd208, 1'b1, 1'b0);
    push_item(8'd209, 1'b1, 1'b1);
    push_item("q", 1'b1, 1'b0);       // code fills up, rest of word dropped
    push_item(8'd222, 1'b1, 1'b0);
    push_item(8'd215, 1'b1, 1'b0);
    push_item(8'd254, 1'b1, 1'b0);
    push_item(8'd241, 1'b1, 1'b0);
    push_item(8'd223, 1'b1, 1'b1);
    wait_idle();

    // length shrinks below what the word already emitted
    set_length(5'd16);
    push_text("Tymczak", 0);
    wait_idle();
    set_length(5'd2);
    push_item("l", 1'b1, 1'b0);
    push_item("x", 1'b1, 1'b1);
    wait_idle();
    // length grows mid-word
    push_text("Ab", 0);
    wait_idle();
    set_length(5'd6);
    push_item(8'd0, 1'b0, 1'b1);
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      set_length(phase_len[p]);
      idle_pct = phase_idle[p];
      stall_pct = phase_stall[p];
      cnt = 0;
      while (cnt < PHASE_ITEMS) cnt += add_random_word();
      wait_idle();
    end

    $display("ran %0d input transactions in %0d words, %0d code characters checked",
             sent_cnt, word_cnt, checked_cnt);
    $display("code lengths 0, 1, 2, 4, 6, 16, 31 and random, under mixed gaps and stalls");
    if (mismatches == 0 && code_q.size() == 0) begin
      $display("[soundex_code_generator_unit] OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[soundex_code_generator_unit] ERROR");
    end
    $finish;
  end

endmodule
